@@ hdl/plc_integer_alu_with_flags_core_defines.svh @@
// ----------------------------------------------------------------------------
// plc integer alu assertion macros
// shared assertion helpers for the plc integer alu core
// ----------------------------------------------------------------------------
`ifndef PLC_INTEGER_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define PLC_INTEGER_ALU_WITH_FLAGS_CORE_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define PLCALU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent in the next cycle
`define PLCALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/plcalu_pkg.sv @@
// ----------------------------------------------------------------------------
// plc integer alu package
// instruction codes, flag positions, shared types and helpers
// ----------------------------------------------------------------------------
package plcalu_pkg;

  // instruction codes
  typedef enum logic [4:0] {
    K_ADD     = 5'd0,
    K_SUB     = 5'd1,
    K_MUL     = 5'd2,
    K_MULWIDE = 5'd3,
    K_DIV     = 5'd4,
    K_DIVPAIR = 5'd5,
    K_INC     = 5'd6,
    K_DEC     = 5'd7,
    K_SHR     = 5'd8,
    K_SHL     = 5'd9,
    K_ROR     = 5'd10,
    K_ROL     = 5'd11,
    K_NEG     = 5'd12,
    K_NOT     = 5'd13,
    K_TOBCD   = 5'd14,
    K_FROMBCD = 5'd15,
    K_CMP     = 5'd16,
    K_ZONE    = 5'd17,
    K_NARROW  = 5'd18,
    K_WIDEN   = 5'd19
  } kind_e;

  // flag bit positions
  localparam int unsigned F_OV   = 0;
  localparam int unsigned F_NEG  = 1;
  localparam int unsigned F_ZERO = 2;
  localparam int unsigned F_DZ   = 3;
  localparam int unsigned F_SC   = 4;
  localparam int unsigned F_SZ   = 5;
  localparam int unsigned F_BCD  = 6;
  localparam int unsigned NFLAGS = 7;

  localparam logic [31:0] MUL_LIM_W  = 32'h0000_3fff;
  localparam logic [31:0] MUL_LIM_DW = 32'h3fff_ffff;
  localparam logic [15:0] BCD_MAX    = 16'd9999;

  // iterative unit operations
  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1,
    UOP_BCD = 2'd2
  } uop_e;

  // top sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic        start;
    uop_e        op;
    logic [31:0] x;
    logic [31:0] y;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] hi;
    logic [31:0] lo;
  } iter_rsp_t;

  // sign extend low half when word wide
  function automatic logic [31:0] ext_w(input logic [31:0] v, input logic w16);
    return w16 ? {{16{v[15]}}, v[15:0]} : v;
  endfunction

  // magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

@@ hdl/plcalu_iter.sv @@
// ----------------------------------------------------------------------------
// plc integer alu iterative unit
// shared shift-add multiplier, restoring divider and binary-to-bcd converter
// ----------------------------------------------------------------------------
module plcalu_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plcalu_pkg::iter_req_t req_i,
  output plcalu_pkg::iter_rsp_t rsp_o
);
  import plcalu_pkg::*;

  logic        busy_q, busy_d;
  uop_e        op_q, op_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d;
  logic [31:0] opnd_q, opnd_d;

  logic [32:0] sum;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [19:0] dig;

  // one step of the selected operation
  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    opnd_d = opnd_q;
    sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opnd_q} : 33'd0);
    trial  = {hi_q, lo_q[31]};
    diff   = trial - {1'b0, opnd_q};
    for (int i = 0; i < 5; i++) begin
      dig[4*i +: 4] = (hi_q[4*i +: 4] >= 4'd5) ? hi_q[4*i +: 4] + 4'd3 : hi_q[4*i +: 4];
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      hi_d   = '0;
      case (req_i.op)
        UOP_MUL: begin
          opnd_d = req_i.x;
          lo_d   = req_i.y;
          cnt_d  = 5'd31;
        end
        UOP_DIV: begin
          opnd_d = req_i.y;
          lo_d   = req_i.x;
          cnt_d  = 5'd31;
        end
        UOP_BCD: begin
          opnd_d = '0;
          lo_d   = {req_i.x[15:0], 16'd0};
          cnt_d  = 5'd15;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        UOP_MUL: begin
          hi_d = sum[32:1];
          lo_d = {sum[0], lo_q[31:1]};
        end
        UOP_DIV: begin
          if (!diff[32]) begin
            hi_d = diff[31:0];
            lo_d = {lo_q[30:0], 1'b1};
          end else begin
            hi_d = trial[31:0];
            lo_d = {lo_q[30:0], 1'b0};
          end
        end
        UOP_BCD: begin
          hi_d = {11'd0, dig, lo_q[31]};
          lo_d = {lo_q[30:0], 1'b0};
        end
        default: begin
          hi_d = hi_q;
        end
      endcase
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= UOP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    opnd_q <= opnd_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;

endmodule

@@ hdl/plc_integer_alu_with_flags_core.sv @@
// ----------------------------------------------------------------------------
// plc integer alu with status flags
// runs one integer plc instruction per item and keeps seven status flags
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | kind, dword, operand_a/b/c
//  out     | output    | out_valid_o/out_ready_i| result, flags, compare bits
//
//  mul, mulwide, div and divpair run 32 steps of the shared iterative unit
//  between accept and result load; tobcd runs 16 steps. all other kinds
//  use no iterative steps (accept, result load).
//  in_ready_o is high only while the sequencer is idle; an item may be taken
//  while the previous result still waits in the output register.
//  reset clears the sequencer, the output valid and all status flags.
`include "plc_integer_alu_with_flags_core_defines.svh"

module plc_integer_alu_with_flags_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         kind_i,
  input  logic               dword_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  input  logic signed [31:0] operand_c_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        result_o,
  output logic               overflow_o,
  output logic               negative_o,
  output logic               zero_o,
  output logic               div_by_zero_o,
  output logic               shift_carry_o,
  output logic               shift_zero_o,
  output logic               bcd_error_o,
  output logic               cmp_equal_o,
  output logic               cmp_less_o,
  output logic               cmp_greater_o
);
  import plcalu_pkg::*;

  state_e      state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [NFLAGS-1:0] flags_q, flags_d;
  logic [31:0] result_q, result_d;
  logic        eq_q, lt_q, gt_q, eq_d, lt_d, gt_d;
  logic [4:0]  kind_q;
  logic        dword_q;
  logic [31:0] a_q, b_q, c_q;

  iter_req_t   req;
  iter_rsp_t   rsp;
  logic        accept, load;
  logic        in_n16;
  logic [31:0] in_sa, in_sb;

  logic        w16, n16;
  logic [31:0] mask, am, bm, sa, sb, sc;
  logic [5:0]  wv;
  logic [31:0] r;
  logic [63:0] prod;
  logic [31:0] prod_s, quot_s, rem_s, magq;
  logic        pneg, qneg, bzero;
  logic [4:0]  nr, rk, idx;
  logic [5:0]  ns;
  logic [63:0] dbl;
  logic [31:0] rot;

  // input side: latch item and kick the iterative unit
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_n16 = !dword_i || (kind_i == K_MULWIDE) || (kind_i == K_DIVPAIR);
  assign in_sa = ext_w(operand_a_i, in_n16);
  assign in_sb = ext_w(operand_b_i, in_n16);

  always_comb begin
    req.start = 1'b0;
    req.op    = UOP_MUL;
    req.x     = mag(in_sa);
    req.y     = mag(in_sb);
    case (kind_i)
      K_MUL, K_MULWIDE: begin
        req.start = accept;
      end
      K_DIV, K_DIVPAIR: begin
        req.start = accept;
        req.op    = UOP_DIV;
      end
      K_TOBCD: begin
        req.start = accept;
        req.op    = UOP_BCD;
        req.x     = {16'd0, operand_a_i[15:0]};
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  plcalu_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // result and flag logic
  always_comb begin
    w16   = !dword_q;
    n16   = w16 || (kind_q == K_MULWIDE) || (kind_q == K_DIVPAIR);
    mask  = w16 ? 32'h0000_ffff : 32'hffff_ffff;
    wv    = w16 ? 6'd16 : 6'd32;
    am    = a_q & mask;
    bm    = b_q & mask;
    sa    = ext_w(a_q, n16);
    sb    = ext_w(b_q, n16);
    sc    = ext_w(c_q, w16);
    prod  = {rsp.hi, rsp.lo};
    pneg  = sa[31] ^ sb[31];
    prod_s = pneg ? (32'd0 - rsp.lo) : rsp.lo;
    qneg  = sa[31] ^ sb[31];
    magq  = rsp.lo;
    quot_s = qneg ? (32'd0 - magq) : magq;
    rem_s = sa[31] ? (32'd0 - rsp.hi) : rsp.hi;
    bzero = n16 ? (b_q[15:0] == 16'd0) : (b_q == 32'd0);
    ns    = b_q[5:0];
    nr    = w16 ? {1'b0, b_q[3:0]} : b_q[4:0];
    rk    = (kind_q == K_ROR) ? nr : 5'(wv - {1'b0, nr});
    dbl   = w16 ? {32'd0, am[15:0], am[15:0]} : {am, am};
    rot   = 32'(dbl >> rk) & mask;
    idx   = '0;
    r     = '0;
    flags_d = flags_q;
    eq_d  = 1'b0;
    lt_d  = 1'b0;
    gt_d  = 1'b0;
    case (kind_q)
      K_ADD, K_SUB, K_INC, K_DEC: begin
        case (kind_q)
          K_ADD:   r = (am + bm) & mask;
          K_SUB:   r = (am - bm) & mask;
          K_INC:   r = (am + 32'd1) & mask;
          default: r = (am - 32'd1) & mask;
        endcase
        case (kind_q)
          K_ADD: flags_d[F_OV] = w16 ? (!(am[15] ^ bm[15]) && (am[15] ^ r[15]))
                                     : (!(am[31] ^ bm[31]) && (am[31] ^ r[31]));
          K_SUB: flags_d[F_OV] = w16 ? ((am[15] ^ bm[15]) && (am[15] ^ r[15]))
                                     : ((am[31] ^ bm[31]) && (am[31] ^ r[31]));
          K_INC: flags_d[F_OV] = w16 ? (am == 32'h0000_7fff) : (am == 32'h7fff_ffff);
          default: flags_d[F_OV] = w16 ? (am == 32'h0000_8000) : (am == 32'h8000_0000);
        endcase
        flags_d[F_NEG]  = w16 ? r[15] : r[31];
        flags_d[F_ZERO] = (r == 32'd0);
      end
      K_MUL: begin
        r = prod_s & mask;
        flags_d[F_OV]   = (mag(sa) != 32'd0) &&
                          (prod > {32'd0, (w16 ? MUL_LIM_W : MUL_LIM_DW)});
        flags_d[F_NEG]  = w16 ? r[15] : r[31];
        flags_d[F_ZERO] = (r == 32'd0);
      end
      K_MULWIDE: begin
        r = prod_s;
        flags_d[F_NEG]  = r[31];
        flags_d[F_ZERO] = (r == 32'd0);
      end
      K_DIV, K_DIVPAIR: begin
        if (bzero) begin
          r = '0;
          flags_d[F_OV]   = 1'b1;
          flags_d[F_NEG]  = 1'b0;
          flags_d[F_ZERO] = 1'b0;
          flags_d[F_DZ]   = 1'b1;
        end else begin
          if (kind_q == K_DIVPAIR) begin
            r = {rem_s[15:0], quot_s[15:0]};
          end else begin
            r = quot_s & mask;
          end
          flags_d[F_OV]   = !qneg && (n16 ? magq[15] : magq[31]);
          flags_d[F_DZ]   = 1'b0;
          flags_d[F_NEG]  = n16 ? quot_s[15] : quot_s[31];
          flags_d[F_ZERO] = n16 ? (quot_s[15:0] == 16'd0) : (quot_s == 32'd0);
        end
      end
      K_SHR, K_SHL: begin
        flags_d[F_SC] = 1'b0;
        if (b_q == 32'd0) begin
          r = am;
        end else if (b_q <= {26'd0, wv}) begin
          if (kind_q == K_SHR) begin
            idx = 5'(ns - 6'd1);
            r   = (ns < wv) ? (am >> ns) : 32'd0;
          end else begin
            idx = 5'(wv - ns);
            r   = (ns < wv) ? ((am << ns) & mask) : 32'd0;
          end
          flags_d[F_SC] = am[idx];
        end else begin
          r = '0;
        end
        flags_d[F_SZ] = (r == 32'd0);
      end
      K_ROR, K_ROL: begin
        flags_d[F_SC] = 1'b0;
        if (nr == 5'd0) begin
          r = am;
        end else begin
          r   = rot;
          idx = (kind_q == K_ROR) ? (nr - 5'd1) : 5'(wv - {1'b0, nr});
          flags_d[F_SC] = am[idx];
        end
        flags_d[F_SZ] = (r == 32'd0);
      end
      K_NEG: r = (32'd0 - am) & mask;
      K_NOT: r = (~am) & mask;
      K_TOBCD: begin
        flags_d[F_BCD] = a_q[15] || (a_q[15:0] > BCD_MAX);
        r = a_q[15] ? 32'd0 : {16'd0, rsp.hi[15:0]};
      end
      K_FROMBCD: begin
        flags_d[F_BCD] = (a_q[15:12] > 4'd9) || (a_q[11:8] > 4'd9) ||
                         (a_q[7:4] > 4'd9) || (a_q[3:0] > 4'd9);
        r = 32'(a_q[15:12]) * 32'd1000 + 32'(a_q[11:8]) * 32'd100 +
            32'(a_q[7:4]) * 32'd10 + 32'(a_q[3:0]);
      end
      K_CMP: begin
        eq_d = (sa == sb);
        lt_d = ($signed(sa) < $signed(sb));
        gt_d = ($signed(sa) > $signed(sb));
      end
      K_ZONE: begin
        eq_d = ($signed(sa) >= $signed(sb)) && ($signed(sa) <= $signed(sc));
        lt_d = ($signed(sa) < $signed(sb));
        gt_d = ($signed(sa) > $signed(sc));
      end
      K_NARROW: begin
        r = {16'd0, a_q[15:0]};
        flags_d[F_NEG] = (a_q[31:16] != 16'd0);
      end
      K_WIDEN: r = ext_w(a_q, 1'b1);
      default: r = '0;
    endcase
  end

  // sequencer
  assign load = (state_q == ST_RUN) && !rsp.busy && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        flags_q <= flags_d;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      dword_q <= dword_i;
      a_q     <= operand_a_i;
      b_q     <= operand_b_i;
      c_q     <= operand_c_i;
    end
    if (load) begin
      result_q <= r;
      eq_q     <= eq_d;
      lt_q     <= lt_d;
      gt_q     <= gt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign overflow_o    = flags_q[F_OV];
  assign negative_o    = flags_q[F_NEG];
  assign zero_o        = flags_q[F_ZERO];
  assign div_by_zero_o = flags_q[F_DZ];
  assign shift_carry_o = flags_q[F_SC];
  assign shift_zero_o  = flags_q[F_SZ];
  assign bcd_error_o   = flags_q[F_BCD];
  assign cmp_equal_o   = eq_q;
  assign cmp_less_o    = lt_q;
  assign cmp_greater_o = gt_q;

  // checks
  `PLCALU_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "ready after accept")
  `PLCALU_ASSERT_NEXT(a_flags_hold, !load, $stable(flags_q), "flags changed without load")
  `PLCALU_ASSERT_NEXT(a_load_valid, load, out_valid_o, "load without valid result")
  `PLCALU_ASSERT_NOW(a_unit_idle, state_q == ST_IDLE, !rsp.busy, "unit busy while idle")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// plc integer alu testbench
// drives random and directed instructions through the alu under random
// handshake idling and checks every result and flag against a local predictor
// ----------------------------------------------------------------------------
module tb_top;
  import plcalu_pkg::*;

  // one expected result item
  typedef struct {
    logic [31:0] result;
    logic [6:0]  flags;
    logic [2:0]  cmp;
  } alu_out_t;

  // predictor and queue of expected results
  class alu_scoreboard;
    logic [6:0] flag_reg;
    alu_out_t   pending[$];
    int         errors;

    function new();
      flag_reg = '0;
      errors = 0;
    endfunction

    function void set_nz(logic [31:0] r, bit w16);
      flag_reg[F_NEG]  = w16 ? r[15] : r[31];
      flag_reg[F_ZERO] = (r == 0);
    endfunction

    function void div_zero();
      flag_reg[F_OV] = 1; flag_reg[F_NEG] = 0; flag_reg[F_ZERO] = 0; flag_reg[F_DZ] = 1;
    endfunction

    // compute expected result for an accepted instruction
    function void note_input(logic [4:0] k, logic dw, logic [31:0] a32, logic [31:0] b32,
                             logic [31:0] c32);
      bit w16;
      int unsigned wd, n;
      logic [31:0] m, sb, a, b, r, ua, ub, lim, ql;
      longint sa, sbv, sc, q, rm, x, y;
      bit c, eq, lt, gt;
      alu_out_t o;
      w16 = (dw == 0);
      wd = w16 ? 16 : 32;
      m = w16 ? 32'hffff : 32'hffff_ffff;
      sb = w16 ? 32'h8000 : 32'h8000_0000;
      a = a32 & m; b = b32 & m; r = 0;
      sa = w16 ? longint'($signed(a32[15:0])) : longint'($signed(a32));
      sbv = w16 ? longint'($signed(b32[15:0])) : longint'($signed(b32));
      sc = w16 ? longint'($signed(c32[15:0])) : longint'($signed(c32));
      eq = 0; lt = 0; gt = 0; c = 0;
      case (k)
        K_ADD: begin
          r = (a + b) & m;
          flag_reg[F_OV] = ((~(a ^ b)) & (a ^ r) & sb) != 0;
          set_nz(r, w16);
        end
        K_SUB: begin
          r = (a - b) & m;
          flag_reg[F_OV] = ((a ^ b) & (a ^ r) & sb) != 0;
          set_nz(r, w16);
        end
        K_MUL: begin
          ua = (sa < 0) ? 32'(-sa) : 32'(sa);
          ub = (sbv < 0) ? 32'(-sbv) : 32'(sbv);
          lim = w16 ? MUL_LIM_W : MUL_LIM_DW;
          r = 32'(sa * sbv) & m;
          flag_reg[F_OV] = (ua != 0) && ((lim / ua) < ub);
          set_nz(r, w16);
        end
        K_MULWIDE: begin
          r = 32'(longint'($signed(a32[15:0])) * longint'($signed(b32[15:0])));
          set_nz(r, 0);
        end
        K_DIV: begin
          if (sbv == 0) div_zero();
          else begin
            q = sa / sbv;
            r = 32'(q) & m;
            flag_reg[F_OV] = q != (w16 ? longint'($signed(r[15:0])) : longint'($signed(r)));
            flag_reg[F_DZ] = 0;
            set_nz(r, w16);
          end
        end
        K_DIVPAIR: begin
          x = $signed(a32[15:0]); y = $signed(b32[15:0]);
          if (y == 0) div_zero();
          else begin
            q = x / y; rm = x % y;
            ql = 32'(q) & 32'hffff;
            r = ((32'(rm) & 32'hffff) << 16) | ql;
            flag_reg[F_OV] = q != longint'($signed(ql[15:0]));
            flag_reg[F_DZ] = 0;
            set_nz(ql, 1);
          end
        end
        K_INC: begin
          r = (a + 1) & m; flag_reg[F_OV] = (a == sb - 1); set_nz(r, w16);
        end
        K_DEC: begin
          r = (a - 1) & m; flag_reg[F_OV] = (a == sb); set_nz(r, w16);
        end
        K_SHR, K_SHL: begin
          if (b32 == 0) r = a;
          else if (b32 <= wd) begin
            n = b32;
            if (k == K_SHR) begin
              c = a[n-1];
              r = (n < wd) ? (a >> n) : 0;
            end else begin
              c = a[wd-n];
              r = (n < wd) ? ((a << n) & m) : 0;
            end
          end else r = 0;
          flag_reg[F_SC] = c; flag_reg[F_SZ] = (r == 0);
        end
        K_ROR, K_ROL: begin
          n = b32 & (wd - 1);
          if (n == 0) r = a;
          else if (k == K_ROR) begin
            r = ((a >> n) | (a << (wd - n))) & m; c = a[n-1];
          end else begin
            r = ((a << n) | (a >> (wd - n))) & m; c = a[wd-n];
          end
          flag_reg[F_SC] = c; flag_reg[F_SZ] = (r == 0);
        end
        K_NEG: r = (0 - a) & m;
        K_NOT: r = (~a) & m;
        K_TOBCD: begin
          x = $signed(a32[15:0]);
          flag_reg[F_BCD] = (x < 0) || (x > 9999);
          if (x >= 0) begin
            ua = 32'(x);
            r = (ua % 10) | ((ua / 10 % 10) << 4) | ((ua / 100 % 10) << 8)
              | ((ua / 1000 % 10) << 12);
          end
        end
        K_FROMBCD: begin
          flag_reg[F_BCD] = (a32[15:12] > 9) || (a32[11:8] > 9) || (a32[7:4] > 9)
                         || (a32[3:0] > 9);
          r = a32[15:12] * 1000 + a32[11:8] * 100 + a32[7:4] * 10 + a32[3:0];
        end
        K_CMP: begin
          eq = sa == sbv; lt = sa < sbv; gt = sa > sbv;
        end
        K_ZONE: begin
          eq = (sa >= sbv) && (sa <= sc); lt = sa < sbv; gt = sa > sc;
        end
        K_NARROW: begin
          r = a32 & 32'hffff; flag_reg[F_NEG] = (a32[31:16] != 0);
        end
        K_WIDEN: r = {{16{a32[15]}}, a32[15:0]};
        default: ;
      endcase
      o.result = r; o.flags = flag_reg; o.cmp = {gt, lt, eq};
      pending.push_back(o);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [31:0] r, logic [6:0] f, logic [2:0] cm);
      alu_out_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.result) begin
        $display("%0t result: expected %h actual %h", $time, e.result, r);
        errors++;
      end
      if (f !== e.flags) begin
        $display("%0t flags: expected %b actual %b", $time, e.flags, f);
        errors++;
      end
      if (cm !== e.cmp) begin
        $display("%0t compare gt/lt/eq: expected %b actual %b", $time, e.cmp, cm);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [4:0] kind;
  logic dword;
  logic signed [31:0] op_a, op_b, op_c;
  logic [31:0] result;
  logic ov, ng, zr, dz, sc, sz, be, ceq, clt, cgt;

  alu_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_off, sending_done;
  int stall_cycles;

  plc_integer_alu_with_flags_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .dword_i(dword),
    .operand_a_i(op_a), .operand_b_i(op_b), .operand_c_i(op_c),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_o(result), .overflow_o(ov), .negative_o(ng), .zero_o(zr),
    .div_by_zero_o(dz), .shift_carry_o(sc), .shift_zero_o(sz), .bcd_error_o(be),
    .cmp_equal_o(ceq), .cmp_less_o(clt), .cmp_greater_o(cgt)
  );

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // send one instruction, with a random idle gap before it
  task automatic send_item(logic [4:0] k, logic d, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; kind <= k; dword <= d; op_a <= a; op_b <= b; op_c <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, d, a, b, c);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return 32'hffff_ffff - $urandom_range(2);
      2: return {16'h0, 16'($urandom_range(16'hffff))};
      3: return $urandom_range(40);
      4: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [4:0] k;
    logic [31:0] a, b;
    k = 5'($urandom_range(31));
    if (k > K_WIDEN && $urandom_range(3) != 0) k = 5'($urandom_range(K_WIDEN));
    a = rand_operand();
    b = rand_operand();
    if (k == K_FROMBCD && $urandom_range(1)) a = {$urandom} & 32'hffff9999;
    if (k == K_TOBCD && $urandom_range(1)) a = $urandom_range(10020);
    send_item(k, 1'($urandom_range(1)), a, b, rand_operand());
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_off) begin
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(result, {be, sz, sc, dz, zr, ng, ov}, {cgt, clt, ceq});
  end

  // watchdog on cycles without any input or output transfer
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_off = 0;
    wait (sending_done == 0 && rst_n === 1);
    repeat (300) @(posedge clk);
    hold_off = 1;
    stall_cycles = 0;
    while (stall_cycles < 200) begin
      @(posedge clk);
      stall_cycles++;
    end
    hold_off = 0;
  end

  initial begin
    logic [4:0] k;
    sb = new();
    sending_done = 0;
    quiet_cycles = 0;
    rst_n = 0;
    in_valid = 0; kind = 0; dword = 0; op_a = 0; op_b = 0; op_c = 0;
    send_idle_pct = 7; recv_idle_pct = 58;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes and special cases
    send_item(K_ADD, 0, 32'h7fff, 1, 0);
    send_item(K_SUB, 1, 32'h8000_0000, 1, 0);
    send_item(K_MUL, 1, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_item(K_MULWIDE, 0, 32'hffff_8000, 32'h8000, 0);
    send_item(K_DIV, 0, 5, 0, 0);
    send_item(K_DIV, 1, 32'h8000_0000, 32'hffff_ffff, 0);
    send_item(K_DIV, 0, 32'h8000, 32'hffff, 0);
    send_item(K_DIVPAIR, 0, 32'h8000, 32'hffff, 0);
    send_item(K_DIVPAIR, 0, -7, 2, 0);
    send_item(K_DIVPAIR, 0, 7, 0, 0);
    send_item(K_INC, 0, 32'h7fff, 0, 0);
    send_item(K_DEC, 1, 32'h8000_0000, 0, 0);
    send_item(K_SHR, 0, 32'h8001, 16, 0);
    send_item(K_SHL, 1, 32'h1, 32, 0);
    send_item(K_SHL, 0, 32'hffff, 32'hffff_ffff, 0);
    send_item(K_ROR, 1, 32'h1, 33, 0);
    send_item(K_ROL, 0, 32'h8000, 0, 0);
    send_item(K_NEG, 1, 32'h8000_0000, 0, 0);
    send_item(K_NOT, 0, 0, 0, 0);
    send_item(K_TOBCD, 0, 9999, 0, 0);
    send_item(K_TOBCD, 0, 32'hffff_ffff, 0, 0);
    send_item(K_FROMBCD, 0, 32'hffff_fa99, 0, 0);
    send_item(K_ZONE, 1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(K_NARROW, 0, 32'h0001_1234, 0, 0);
    send_item(K_WIDEN, 0, 32'h0000_8000, 0, 0);
    k = 20; send_item(k, 1, 1, 1, 1);

    // random, three idling phases
    for (int i = 0; i < 1650; i++) begin
      if (i == 550) begin send_idle_pct = 58; recv_idle_pct = 7; end
      if (i == 1100) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_random();
    end
    in_valid <= 0;
    sending_done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
